>>> hw/rtl/drcg_pkg.sv
// Shared types, constants and color functions for the dimmed rainbow cycle generator.
// Used by drcg_ctrl, drcg_datapath and the top level; depends on nothing.
package drcg_pkg;

    localparam int PIXEL_COUNT_DEF = 16;
    localparam int PIXEL_MAX       = 64;
    localparam int IDX_W           = 6;
    localparam int CH_W            = 8;
    localparam int TIME_W          = 32;
    localparam int LEVEL_W         = 4;
    localparam int INTERVAL_W      = 16;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 32;
    localparam int PROD_W          = 16;

    localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = 4'd10;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHTNESS = 1'b0,
        REG_INTERVAL   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load_now;   // input transaction taken
        logic check;      // evaluate due time, arm frame
        logic issue;      // launch one pixel into the pipeline
    } t_cmd;

    typedef struct packed {
        logic fire;       // current item is due
        logic last_pix;   // pixel counter sits on the final pixel
        logic adv;        // pipeline may advance this cycle
    } t_status;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Three-segment color wheel, w = 255 - pos.
    function automatic t_rgb wheel_color(input logic [CH_W-1:0] pos);
        logic [CH_W-1:0] w;
        logic [CH_W-1:0] u;
        logic [CH_W-1:0] u3;
        t_rgb c;
        w = ~pos;
        c = '0;
        if (w < 8'd85) begin
            u3 = 8'(w * 2'd3);
            c.red  = 8'd255 - u3;
            c.blue = u3;
        end else if (w < 8'd170) begin
            u  = w - 8'd85;
            u3 = 8'(u * 2'd3);
            c.green = u3;
            c.blue  = 8'd255 - u3;
        end else begin
            u  = w - 8'd170;
            u3 = 8'(u * 2'd3);
            c.red   = u3;
            c.green = 8'd255 - u3;
        end
        return c;
    endfunction

    // Brightness ceiling floor(255*level/10), level clamped to 1..10.
    function automatic logic [CH_W-1:0] level_ceiling(input logic [LEVEL_W-1:0] level);
        logic [CH_W-1:0] c;
        unique case (level)
            4'd0, 4'd1: c = 8'd25;
            4'd2:       c = 8'd51;
            4'd3:       c = 8'd76;
            4'd4:       c = 8'd102;
            4'd5:       c = 8'd127;
            4'd6:       c = 8'd153;
            4'd7:       c = 8'd178;
            4'd8:       c = 8'd204;
            4'd9:       c = 8'd229;
            default:    c = 8'd255;
        endcase
        return c;
    endfunction

    // Exact floor(x/255) for any x up to 65279, which covers every product of two 8-bit values.
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W:0] s;
        s = {1'b0, x} + {9'd0, x[PROD_W-1:8]} + 17'd1;
        return s[PROD_W-1:8];
    endfunction

endpackage

>>> hw/rtl/drcg_ctrl.sv
// Frame sequencer for the dimmed rainbow cycle generator.
// Depends on drcg_pkg; drives commands into drcg_datapath.
module drcg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  drcg_pkg::t_status i_status,
    output drcg_pkg::t_cmd    o_cmd
);
    import drcg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.fire ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_status.adv && i_status.last_pix) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready     = (r_state == ST_IDLE);
        o_cmd.load_now = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.check    = (r_state == ST_CHECK);
        o_cmd.issue    = (r_state == ST_EMIT) && i_status.adv;
    end

endmodule

>>> hw/rtl/drcg_datapath.sv
// Timing state, pixel position stepping and color pipeline of the rainbow generator.
// Depends on drcg_pkg; controlled by drcg_ctrl.
module drcg_datapath #(
    parameter int PIXEL_COUNT = drcg_pkg::PIXEL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  drcg_pkg::t_cmd                  i_cmd,
    output drcg_pkg::t_status               o_status,
    input  logic [drcg_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_cfg_we,
    input  logic [drcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drcg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic                            o_m_tlast,
    output logic [drcg_pkg::IDX_W-1:0]      o_pixel_index,
    output logic [drcg_pkg::CH_W-1:0]       o_red_level,
    output logic [drcg_pkg::CH_W-1:0]       o_green_level,
    output logic [drcg_pkg::CH_W-1:0]       o_blue_level
);
    import drcg_pkg::*;

    // Pixel i sits at i*256/PIXEL_COUNT: step by quotient, carry the remainder.
    localparam logic [8:0]       POS_STEP = 9'(256 / PIXEL_COUNT);
    localparam logic [IDX_W:0]   REM_STEP = (IDX_W + 1)'(256 % PIXEL_COUNT);
    localparam logic [IDX_W:0]   PIX_N    = (IDX_W + 1)'(PIXEL_COUNT);
    localparam logic [IDX_W-1:0] PIX_LAST = IDX_W'(PIXEL_COUNT - 1);

    logic [LEVEL_W-1:0]    r_level;
    logic [INTERVAL_W-1:0] r_interval;
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_due;
    logic                  r_started;
    logic [CH_W-1:0]       r_offset;

    logic [IDX_W-1:0]      r_pix;
    logic [CH_W-1:0]       r_qacc;
    logic [IDX_W-1:0]      r_rem;

    logic                  r_s1_valid;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_s1_last;
    logic [PROD_W-1:0]     r_prod_r;
    logic [PROD_W-1:0]     r_prod_g;
    logic [PROD_W-1:0]     r_prod_b;

    logic                  r_out_valid;
    logic                  r_out_last;
    logic [IDX_W-1:0]      r_out_idx;
    logic [CH_W-1:0]       r_out_r;
    logic [CH_W-1:0]       r_out_g;
    logic [CH_W-1:0]       r_out_b;

    logic                  adv;
    logic                  fire;
    logic [IDX_W:0]        rem_sum;
    logic                  rem_wrap;
    logic [CH_W-1:0]       pos;
    logic [CH_W-1:0]       ceiling;
    t_rgb                  color;

    assign adv      = !r_out_valid || i_m_tready;
    assign fire     = !r_started || (r_now >= r_due);
    assign rem_sum  = {1'b0, r_rem} + REM_STEP;
    assign rem_wrap = (rem_sum >= PIX_N);
    assign pos      = r_qacc + r_offset;
    assign ceiling  = level_ceiling(r_level);
    assign color    = wheel_color(pos);

    always_comb begin
        o_status.fire     = fire;
        o_status.last_pix = (r_pix == PIX_LAST);
        o_status.adv      = adv;
    end

    // Configuration and timing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= LEVEL_RESET;
            r_interval <= INTERVAL_RESET;
            r_due      <= '0;
            r_started  <= 1'b0;
            r_offset   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_index))
                    REG_BRIGHTNESS: r_level    <= i_cfg_data[LEVEL_W-1:0];
                    REG_INTERVAL:   r_interval <= i_cfg_data[INTERVAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.check && fire) begin
                r_due     <= r_now + {{(TIME_W - INTERVAL_W){1'b0}}, r_interval};
                r_started <= 1'b1;
                r_offset  <= r_offset + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_now) r_now <= i_now_ms;
    end

    // Pixel counter and wheel position accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_pix  <= '0;
            r_qacc <= '0;
            r_rem  <= '0;
        end else if (i_cmd.issue) begin
            r_pix  <= r_pix + 1'b1;
            r_qacc <= r_qacc + POS_STEP[CH_W-1:0] + {7'd0, rem_wrap};
            r_rem  <= rem_wrap ? IDX_W'(rem_sum - PIX_N) : rem_sum[IDX_W-1:0];
        end
    end

    // Stage 1: wheel color times ceiling; stage 2: divide by 255 into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_cmd.issue;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_idx   <= r_pix;
            r_s1_last  <= (r_pix == PIX_LAST);
            r_prod_r   <= color.red * ceiling;
            r_prod_g   <= color.green * ceiling;
            r_prod_b   <= color.blue * ceiling;
            r_out_idx  <= r_s1_idx;
            r_out_last <= r_s1_last;
            r_out_r    <= div255(r_prod_r);
            r_out_g    <= div255(r_prod_g);
            r_out_b    <= div255(r_prod_b);
        end
    end

    assign o_m_tvalid    = r_out_valid;
    assign o_m_tlast     = r_out_last;
    assign o_pixel_index = r_out_idx;
    assign o_red_level   = r_out_r;
    assign o_green_level = r_out_g;
    assign o_blue_level  = r_out_b;

endmodule

>>> hw/rtl/dimmed_rainbow_cycle_generator_core.sv
// Dimmed rainbow cycle generator: each time stamp that reaches the due time advances
// the wheel offset and streams one scaled color per pixel, the last one with tlast.
// A time stamp is taken in one cycle and checked in the next; one that is not due ends
// there. A due one then launches one pixel per cycle, while the output is not held off,
// into a two-stage multiply and divide pipeline; the next time stamp is taken only
// after the last pixel has been launched.
// The first time stamp after reset always fires. Brightness is clamped to 1..10.
// Depends on drcg_pkg, drcg_ctrl and drcg_datapath.
module dimmed_rainbow_cycle_generator_core #(
    parameter int PIXEL_COUNT = drcg_pkg::PIXEL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [drcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [drcg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [drcg_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] now_ms
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [drcg_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [5:0] pixel_index, [13:6] red_level,
                                                           // [21:14] green_level,
                                                           // [29:22] blue_level, [31:30] zero
    output logic                            m_axis_tlast   // last_pixel
);
    import drcg_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [IDX_W-1:0]  pixel_index;
    logic [CH_W-1:0]   red_level;
    logic [CH_W-1:0]   green_level;
    logic [CH_W-1:0]   blue_level;

    drcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    drcg_datapath #(
        .PIXEL_COUNT (PIXEL_COUNT)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_now_ms      (s_axis_tdata[TIME_W-1:0]),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tlast     (m_axis_tlast),
        .o_pixel_index (pixel_index),
        .o_red_level   (red_level),
        .o_green_level (green_level),
        .o_blue_level  (blue_level)
    );

    assign m_axis_tdata = {2'b00, blue_level, green_level, red_level, pixel_index};

endmodule
